// ===== rtl/legacy_frame_reassembler_core_macros.svh =====
// assertion macros for the frame reassembler
// each macro expects clk and rst in scope
`ifndef LEGACY_FRAME_REASSEMBLER_CORE_MACROS_SVH
`define LEGACY_FRAME_REASSEMBLER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define LFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LFR_ASSERT_NOW(lbl, ante, cons, msg)
`define LFR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/lfr_pkg.sv =====
package lfr_pkg;

  // field widths
  localparam int BYTE_W   = 8;
  localparam int POS_W    = 6;
  localparam int OFFSET_W = 6;
  localparam int EXT_W    = 7;
  localparam int COUNT_W  = 4;
  localparam int CLASS_W  = 3;

  // defaults for the top-level parameter
  localparam int FRAME_BYTES = 44;

  // packet bytes at or beyond this position are not stored
  localparam int MAX_PACKET_BYTES = 48;

  // packet classes
  localparam logic [CLASS_W-1:0] CLS_IGNORE = 3'd0;
  localparam logic [CLASS_W-1:0] CLS_FIRST  = 3'd1;
  localparam logic [CLASS_W-1:0] CLS_CONT1  = 3'd2;
  localparam logic [CLASS_W-1:0] CLS_CONTN  = 3'd3;
  localparam logic [CLASS_W-1:0] CLS_FINAL  = 3'd4;

  // packet markers and lengths
  localparam logic [BYTE_W-1:0] TAG_CONT1 = 8'hFE;
  localparam logic [BYTE_W-1:0] TAG_CONTN = 8'hFF;
  localparam logic [BYTE_W-1:0] TAG_FINAL = 8'hF8;
  localparam logic [POS_W-1:0]  SHORT_LEN = 6'd5;
  localparam logic [POS_W-1:0]  FINAL_LEN = 6'd33;

  // frame layout
  localparam logic [OFFSET_W-1:0] HDR_OFFSET  = 6'd4;
  localparam logic [BYTE_W-1:0]   HDR_MARK    = 8'h80;
  localparam logic [EXT_W-1:0]    FIRST_BASE  = 7'd5;
  localparam logic [EXT_W-1:0]    CHUNK_BASE  = 7'd12;
  localparam logic [POS_W-1:0]    CHUNK_BYTES = 6'd4;
  localparam logic [POS_W-1:0]    FINAL_BYTES = 6'd32;
  localparam logic [COUNT_W-1:0]  CHUNK_FULL  = 4'd8;

  // controller to datapath
  typedef struct packed {
    logic                wr_en;
    logic [OFFSET_W-1:0] wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                clr_all;
    logic                clr_en;
    logic [EXT_W-1:0]    clr_base;
    logic [POS_W-1:0]    clr_cnt;
    logic                rd_en;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_last;
  } dp_status_t;

endpackage

// ===== rtl/lfr_ctrl.sv =====
module lfr_ctrl #(
  parameter int FRAME_BYTES = lfr_pkg::FRAME_BYTES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lfr_pkg::BYTE_W-1:0]   data_byte,
  input  logic [lfr_pkg::POS_W-1:0]    byte_position,
  input  logic [lfr_pkg::POS_W-1:0]    packet_length,
  input  logic                         packet_end,
  input  lfr_pkg::dp_status_t          status,
  output lfr_pkg::dp_cmd_t             cmd,
  output logic                         busy
);

  localparam logic [0:0] S_IDLE = 1'b0;
  localparam logic [0:0] S_EMIT = 1'b1;

  logic [0:0]                    state, state_next;
  logic [lfr_pkg::CLASS_W-1:0]   pkt_class, pkt_class_next;
  logic [lfr_pkg::COUNT_W-1:0]   chunk_count, chunk_count_next;

  logic                          accept;
  logic                          pos_zero;
  logic [lfr_pkg::CLASS_W-1:0]   cls_new, cls_eff;
  logic [lfr_pkg::EXT_W-1:0]     cnt_off;
  logic [lfr_pkg::EXT_W-1:0]     addr_ext;
  logic                          in_range;
  logic [lfr_pkg::COUNT_W-1:0]   count_upd;

  assign accept   = start && (state == S_IDLE);
  assign pos_zero = (byte_position == '0);
  assign busy     = (state == S_EMIT);
  assign cnt_off  = lfr_pkg::EXT_W'({chunk_count, 2'b00});

  // classify on the first byte of a packet
  always_comb begin
    priority if (data_byte != lfr_pkg::TAG_CONT1 && data_byte != lfr_pkg::TAG_CONTN &&
                 packet_length == lfr_pkg::SHORT_LEN) begin
      cls_new = lfr_pkg::CLS_FIRST;
    end else if (data_byte == lfr_pkg::TAG_CONT1 && packet_length == lfr_pkg::SHORT_LEN) begin
      cls_new = lfr_pkg::CLS_CONT1;
    end else if (data_byte == lfr_pkg::TAG_CONTN && packet_length == lfr_pkg::SHORT_LEN &&
                 chunk_count != '0 && chunk_count < lfr_pkg::CHUNK_FULL) begin
      cls_new = lfr_pkg::CLS_CONTN;
    end else if (data_byte == lfr_pkg::TAG_FINAL && packet_length == lfr_pkg::FINAL_LEN) begin
      cls_new = lfr_pkg::CLS_FINAL;
    end else begin
      cls_new = lfr_pkg::CLS_IGNORE;
    end
  end

  assign cls_eff = pos_zero ? cls_new : pkt_class;

  // target offset and range per class
  always_comb begin
    in_range = 1'b0;
    addr_ext = '0;
    unique case (cls_eff)
      lfr_pkg::CLS_FIRST: begin
        in_range = (byte_position < lfr_pkg::SHORT_LEN);
        addr_ext = lfr_pkg::FIRST_BASE + lfr_pkg::EXT_W'(byte_position);
      end
      lfr_pkg::CLS_CONT1: begin
        in_range = (byte_position != '0) && (byte_position <= lfr_pkg::CHUNK_BYTES);
        addr_ext = lfr_pkg::CHUNK_BASE - 7'd1 + lfr_pkg::EXT_W'(byte_position);
      end
      lfr_pkg::CLS_CONTN: begin
        in_range = (byte_position != '0) && (byte_position <= lfr_pkg::CHUNK_BYTES);
        addr_ext = lfr_pkg::CHUNK_BASE - 7'd1 + cnt_off + lfr_pkg::EXT_W'(byte_position);
      end
      lfr_pkg::CLS_FINAL: begin
        in_range = (byte_position != '0) && (byte_position <= lfr_pkg::FINAL_BYTES);
        addr_ext = lfr_pkg::CHUNK_BASE - 7'd1 + lfr_pkg::EXT_W'(byte_position);
      end
      default: begin
        in_range = 1'b0;
        addr_ext = '0;
      end
    endcase
  end

  // count after the packet's final byte
  always_comb begin
    unique case (cls_eff)
      lfr_pkg::CLS_CONT1: count_upd = 4'd1;
      lfr_pkg::CLS_CONTN: count_upd = chunk_count + 4'd1;
      lfr_pkg::CLS_FINAL: count_upd = lfr_pkg::CHUNK_FULL;
      default:            count_upd = '0;
    endcase
  end

  // commands to the datapath
  always_comb begin
    cmd          = '0;
    cmd.wr_en    = accept && in_range &&
                   (32'(byte_position) < lfr_pkg::MAX_PACKET_BYTES) &&
                   (32'(addr_ext) < FRAME_BYTES);
    cmd.wr_addr  = addr_ext[lfr_pkg::OFFSET_W-1:0];
    cmd.wr_data  = data_byte;
    cmd.rd_en    = (state == S_EMIT);
    if (accept && pos_zero) begin
      unique case (cls_new)
        lfr_pkg::CLS_FIRST: cmd.clr_all = 1'b1;
        lfr_pkg::CLS_CONT1: begin
          cmd.clr_en   = 1'b1;
          cmd.clr_base = lfr_pkg::CHUNK_BASE;
          cmd.clr_cnt  = lfr_pkg::CHUNK_BYTES;
        end
        lfr_pkg::CLS_CONTN: begin
          cmd.clr_en   = 1'b1;
          cmd.clr_base = lfr_pkg::CHUNK_BASE + cnt_off;
          cmd.clr_cnt  = lfr_pkg::CHUNK_BYTES;
        end
        lfr_pkg::CLS_FINAL: begin
          cmd.clr_en   = 1'b1;
          cmd.clr_base = lfr_pkg::CHUNK_BASE;
          cmd.clr_cnt  = lfr_pkg::FINAL_BYTES;
        end
        default: cmd.clr_en = 1'b0;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next       = state;
    pkt_class_next   = pkt_class;
    chunk_count_next = chunk_count;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (packet_end) begin
            pkt_class_next   = lfr_pkg::CLS_IGNORE;
            chunk_count_next = count_upd;
            if (count_upd == lfr_pkg::CHUNK_FULL) begin
              state_next = S_EMIT;
            end
          end else begin
            pkt_class_next = cls_eff;
          end
        end
      end
      S_EMIT: begin
        if (status.rd_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      pkt_class   <= lfr_pkg::CLS_IGNORE;
      chunk_count <= '0;
    end else begin
      state       <= state_next;
      pkt_class   <= pkt_class_next;
      chunk_count <= chunk_count_next;
    end
  end

endmodule

// ===== rtl/lfr_dpath.sv =====
module lfr_dpath #(
  parameter int FRAME_BYTES = lfr_pkg::FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lfr_pkg::dp_cmd_t              cmd,
  output lfr_pkg::dp_status_t           status,
  output logic                          result_strobe,
  output logic [lfr_pkg::BYTE_W-1:0]    frame_byte,
  output logic [lfr_pkg::OFFSET_W-1:0]  frame_offset,
  output logic                          frame_last
);

  localparam logic [lfr_pkg::OFFSET_W-1:0] LAST_ADDR = lfr_pkg::OFFSET_W'(FRAME_BYTES - 1);

  logic [lfr_pkg::BYTE_W-1:0]   mem [FRAME_BYTES];
  logic [FRAME_BYTES-1:0]       valid, valid_next;
  logic [FRAME_BYTES-1:0]       clr_vec;
  logic                         hdr_set;
  logic [lfr_pkg::OFFSET_W-1:0] rd_addr;
  logic [lfr_pkg::BYTE_W-1:0]   rd_data;
  logic                         rd_ok;
  logic                         rd_hdr;

  // frame memory
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // per-entry valid bits: cleared entries read as zero, except the header entry once set
  always_comb begin
    for (int i = 0; i < FRAME_BYTES; i++) begin
      clr_vec[i] = cmd.clr_all ||
                   (cmd.clr_en && (lfr_pkg::EXT_W'(i) >= cmd.clr_base) &&
                    (lfr_pkg::EXT_W'(i) < cmd.clr_base + lfr_pkg::EXT_W'(cmd.clr_cnt)));
      valid_next[i] = (valid[i] && !clr_vec[i]) ||
                      (cmd.wr_en && cmd.wr_addr == lfr_pkg::OFFSET_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      hdr_set <= 1'b0;
    end else begin
      valid <= valid_next;
      if (cmd.clr_all) begin
        hdr_set <= 1'b1;
      end
    end
  end

  // emission read sequence
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_addr       <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.rd_en;
      if (cmd.rd_en) begin
        rd_addr <= (rd_addr == LAST_ADDR) ? '0 : rd_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_ok        <= valid[rd_addr];
      rd_hdr       <= hdr_set && (rd_addr == lfr_pkg::HDR_OFFSET);
      frame_offset <= rd_addr;
      frame_last   <= (rd_addr == LAST_ADDR);
    end
  end

  assign status.rd_last = (rd_addr == LAST_ADDR);
  assign frame_byte     = rd_ok ? rd_data : (rd_hdr ? lfr_pkg::HDR_MARK : '0);

endmodule

// ===== rtl/legacy_frame_reassembler_core.sv =====
// Status frame reassembler for one legacy panel source. Packet bytes come in
// one per cycle on start, each with its position, its packet's length and an
// end mark; an input byte is taken when start is high and busy is low, so
// the block takes one byte every cycle while it is not emitting. When a
// packet completes the frame (chunk count reaches 8), busy rises on the next
// cycle and stays high while the whole frame memory is read
// out one entry per cycle through its single read port. Each frame byte is
// shown for exactly one cycle with result_strobe, in the cycle after its read,
// in offset order; frame_last marks the final byte. The receiver cannot
// stall: it must take every strobed byte. No clearing pass is needed after
// reset.
`include "legacy_frame_reassembler_core_macros.svh"

module legacy_frame_reassembler_core #(
  parameter int FRAME_BYTES = lfr_pkg::FRAME_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lfr_pkg::BYTE_W-1:0]    data_byte,
  input  logic [lfr_pkg::POS_W-1:0]     byte_position,
  input  logic [lfr_pkg::POS_W-1:0]     packet_length,
  input  logic                          packet_end,
  output logic                          result_strobe,
  output logic [lfr_pkg::BYTE_W-1:0]    frame_byte,
  output logic [lfr_pkg::OFFSET_W-1:0]  frame_offset,
  output logic                          frame_last
);

  lfr_pkg::dp_cmd_t    cmd;
  lfr_pkg::dp_status_t status;

  // packet classification and sequencing
  lfr_ctrl #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .data_byte     (data_byte),
    .byte_position (byte_position),
    .packet_length (packet_length),
    .packet_end    (packet_end),
    .status        (status),
    .cmd           (cmd),
    .busy          (busy)
  );

  // frame storage and read-out
  lfr_dpath #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .result_strobe (result_strobe),
    .frame_byte    (frame_byte),
    .frame_offset  (frame_offset),
    .frame_last    (frame_last)
  );

  // checks
  `LFR_ASSERT_NOW(a_last_offset, result_strobe && frame_last, frame_offset == lfr_pkg::OFFSET_W'(FRAME_BYTES - 1), "last byte not at final offset")
  `LFR_ASSERT_NEXT(a_burst_cont, result_strobe && !frame_last, result_strobe && frame_offset == $past(frame_offset) + 1'b1, "frame burst broken")
  `LFR_ASSERT_NEXT(a_burst_start, $rose(busy), result_strobe && frame_offset == '0, "frame burst does not start at offset zero")
  `LFR_ASSERT_NOW(a_low_zero, result_strobe && frame_offset < lfr_pkg::HDR_OFFSET, frame_byte == '0, "unwritten leading bytes not zero")

endmodule
